@@ design/pmx_pkg.sv @@
package pmx_pkg;

  localparam int unsigned CUT_W = 4;
  localparam int unsigned POS_W = CUT_W + 1;

  typedef struct packed {
    logic load;
    logic step;
  } pmx_lane_ctrl_t;

endpackage

@@ design/pmx_lane.sv @@
module pmx_lane
  import pmx_pkg::*;
#(
  parameter int unsigned GENES     = 10,
  parameter int unsigned GENE_BITS = 4
) (
  input  logic                 clk_i,
  input  pmx_lane_ctrl_t       ctrl_i,
  input  logic                 outside_i,
  input  logic [GENE_BITS-1:0] init_i,
  input  logic [GENES-1:0]     inseg_i,
  input  logic [GENE_BITS-1:0] own_i   [GENES],
  input  logic [GENE_BITS-1:0] other_i [GENES],
  output logic                 hit_o,
  output logic [GENE_BITS-1:0] value_o
);

  logic [GENE_BITS-1:0] value_q;
  logic [GENE_BITS-1:0] value_d;
  logic                 match;

  // lowest matching segment position wins
  always_comb begin
    match   = 1'b0;
    value_d = value_q;
    for (int p = GENES - 1; p >= 0; p--) begin
      if (inseg_i[p] && (own_i[p] == value_q)) begin
        match   = 1'b1;
        value_d = other_i[p];
      end
    end
  end

  assign hit_o   = match && outside_i;
  assign value_o = value_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      value_q <= init_i;
    end else if (ctrl_i.step && hit_o) begin
      value_q <= value_d;
    end
  end

endmodule

@@ design/pmx_merge.sv @@
module pmx_merge #(
  parameter int unsigned GENES     = 10,
  parameter int unsigned GENE_BITS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         err_i,
  input  logic [GENE_BITS-1:0]         first_i  [GENES],
  input  logic [GENE_BITS-1:0]         second_i [GENES],
  output logic                         ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [GENES*GENE_BITS-1:0]   first_child_o,
  output logic [GENES*GENE_BITS-1:0]   second_child_o,
  output logic                         cut_error_o
);

  logic                       valid_q;
  logic [GENES*GENE_BITS-1:0] first_q;
  logic [GENES*GENE_BITS-1:0] second_q;
  logic [GENES*GENE_BITS-1:0] first_d;
  logic [GENES*GENE_BITS-1:0] second_d;
  logic                       err_q;

  always_comb begin
    for (int k = 0; k < GENES; k++) begin
      first_d[k*GENE_BITS +: GENE_BITS]  = first_i[k];
      second_d[k*GENE_BITS +: GENE_BITS] = second_i[k];
    end
  end

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      first_q  <= first_d;
      second_q <= second_d;
      err_q    <= err_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign first_child_o  = first_q;
  assign second_child_o = second_q;
  assign cut_error_o    = err_q;

endmodule

@@ design/partially_mapped_crossover.sv @@
// channel  signals                                        direction
// in       in_valid_i / in_ready_o, parents, cut bounds   into block
// out      out_valid_o / out_ready_i, children, cut_error out of block
//
// an item is taken, then every gene lane outside the segment that still sits
// on a segment value takes one mapping step per cycle until none does, at
// most GENES steps
// reset clears the controller and the output valid, no clearing pass
// a stalled output holds its item while the next item is already walking

module partially_mapped_crossover
  import pmx_pkg::*;
#(
  parameter int unsigned GENES     = 10,
  parameter int unsigned GENE_BITS = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [GENES*GENE_BITS-1:0] first_parent_i,
  input  logic [GENES*GENE_BITS-1:0] second_parent_i,
  input  logic [CUT_W-1:0]           cut_start_i,
  input  logic [CUT_W-1:0]           cut_end_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [GENES*GENE_BITS-1:0] first_child_o,
  output logic [GENES*GENE_BITS-1:0] second_child_o,
  output logic                       cut_error_o
);

  localparam int unsigned CNT_W = $clog2(GENES + 1);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e               state_q;
  logic [CNT_W-1:0]     cnt_q;

  logic [GENE_BITS-1:0] a_q [GENES];
  logic [GENE_BITS-1:0] b_q [GENES];
  logic [GENE_BITS-1:0] a_d [GENES];
  logic [GENE_BITS-1:0] b_d [GENES];
  logic [GENES-1:0]     inseg_q;
  logic [GENES-1:0]     inseg_d;
  logic                 err_q;
  logic                 err_d;

  logic [POS_W-1:0]     lo;
  logic [POS_W-1:0]     hi;

  logic [GENES-1:0]     hit_a;
  logic [GENES-1:0]     hit_b;
  logic [GENE_BITS-1:0] val_a [GENES];
  logic [GENE_BITS-1:0] val_b [GENES];

  pmx_lane_ctrl_t       ctrl;
  logic                 accept;
  logic                 any_hit;
  logic                 cnt_full;
  logic                 walk_done;
  logic                 merge_ready;
  logic                 push;

  always_comb begin
    lo    = {1'b0, cut_start_i};
    hi    = ({1'b0, cut_end_i} > POS_W'(GENES)) ? POS_W'(GENES) : {1'b0, cut_end_i};
    err_d = lo >= hi;
    for (int k = 0; k < GENES; k++) begin
      inseg_d[k] = (POS_W'(k) >= lo) && (POS_W'(k) < hi);
      a_d[k]     = inseg_d[k] ? second_parent_i[k*GENE_BITS +: GENE_BITS]
                              : first_parent_i[k*GENE_BITS +: GENE_BITS];
      b_d[k]     = inseg_d[k] ? first_parent_i[k*GENE_BITS +: GENE_BITS]
                              : second_parent_i[k*GENE_BITS +: GENE_BITS];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign any_hit    = (|hit_a) || (|hit_b);
  assign cnt_full   = (cnt_q == CNT_W'(GENES));
  assign walk_done  = !any_hit || cnt_full;
  assign ctrl.load  = accept;
  assign ctrl.step  = (state_q == S_WALK) && any_hit && !cnt_full;
  assign push       = (state_q == S_WALK) && walk_done && merge_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_WALK;
            cnt_q   <= '0;
          end
        end
        S_WALK: begin
          if (push) begin
            state_q <= S_IDLE;
          end else if (ctrl.step) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q     <= a_d;
      b_q     <= b_d;
      inseg_q <= inseg_d;
      err_q   <= err_d;
    end
  end

  for (genvar k = 0; k < GENES; k++) begin : g_lane
    pmx_lane #(
      .GENES     (GENES),
      .GENE_BITS (GENE_BITS)
    ) u_lane_a (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .outside_i (!inseg_q[k]),
      .init_i    (a_d[k]),
      .inseg_i   (inseg_q),
      .own_i     (a_q),
      .other_i   (b_q),
      .hit_o     (hit_a[k]),
      .value_o   (val_a[k])
    );

    pmx_lane #(
      .GENES     (GENES),
      .GENE_BITS (GENE_BITS)
    ) u_lane_b (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .outside_i (!inseg_q[k]),
      .init_i    (b_d[k]),
      .inseg_i   (inseg_q),
      .own_i     (b_q),
      .other_i   (a_q),
      .hit_o     (hit_b[k]),
      .value_o   (val_b[k])
    );
  end

  pmx_merge #(
    .GENES     (GENES),
    .GENE_BITS (GENE_BITS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .err_i          (err_q),
    .first_i        (val_a),
    .second_i       (val_b),
    .ready_o        (merge_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_child_o  (first_child_o),
    .second_child_o (second_child_o),
    .cut_error_o    (cut_error_o)
  );

endmodule

@@ design/pmx_checker.sv @@
module pmx_checker
  import pmx_pkg::*;
#(
  parameter int unsigned GENES     = 10,
  parameter int unsigned GENE_BITS = 4
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [GENES*GENE_BITS-1:0] first_parent_i,
  input logic [GENES*GENE_BITS-1:0] second_parent_i,
  input logic [CUT_W-1:0]           cut_start_i,
  input logic [CUT_W-1:0]           cut_end_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [GENES*GENE_BITS-1:0] first_child_o,
  input logic [GENES*GENE_BITS-1:0] second_child_o,
  input logic                       cut_error_o
);

  // one item in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
  else $error("input taken again straight after an item");

  // a result only appears at the end of a walk
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
  else $error("result appeared without an item in flight");

  // input reopens only once the result stands at the output
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
  else $error("input reopened without a result");

  // a waiting input item keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> in_valid_i && $stable(first_parent_i) &&
      $stable(second_parent_i) && $stable(cut_start_i) && $stable(cut_end_i))
  else $error("waiting input item changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(first_child_o) &&
      $stable(second_child_o) && $stable(cut_error_o))
  else $error("stalled result changed");

endmodule

bind partially_mapped_crossover pmx_checker #(
  .GENES     (GENES),
  .GENE_BITS (GENE_BITS)
) u_pmx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .first_parent_i  (first_parent_i),
  .second_parent_i (second_parent_i),
  .cut_start_i     (cut_start_i),
  .cut_end_i       (cut_end_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .first_child_o   (first_child_o),
  .second_child_o  (second_child_o),
  .cut_error_o     (cut_error_o)
);
